@@ rtl/core/sv39pm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sv39pm_pkg
// shared constants and types for the sv39 page mapper
// ----------------------------------------------------------------------------
package sv39pm_pkg;

  // table pool
  localparam int TABLES      = 64;
  localparam int TAB_W       = $clog2(TABLES);
  localparam int ENTRY_W     = 9;
  localparam int ENTRIES     = 1 << ENTRY_W;
  localparam int ADDR_W      = TAB_W + ENTRY_W;
  localparam int STORE_DEPTH = TABLES * ENTRIES;

  // field widths
  localparam int WORD_W  = 64;
  localparam int PPN_W   = 44;
  localparam int VPN_W   = 27;
  localparam int VA_W    = 39;
  localparam int PA_W    = 56;
  localparam int SIZE_W  = 31;
  localparam int PROT_W  = 10;
  localparam int PAGE_SH = 12;
  localparam int CNT_W   = 19;
  localparam int TNUM_W  = 6;

  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(1 << 30);

  // request codes
  localparam logic FUNC_MAP  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_TABLE = 2'd1;
  localparam logic [1:0] STAT_FOREIGN  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RWAIT,
    ST_WRD,
    ST_WCHK,
    ST_SWP,
    ST_ALLOC,
    ST_LEAF
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [CNT_W-1:0]  pages;
    logic [WORD_W-1:0] word;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/sv39pm_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sv39pm_store
// table store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module sv39pm_store (
  input  wire logic                       clk,
  input  wire sv39pm_pkg::mem_req_t       req,
  output logic [sv39pm_pkg::WORD_W-1:0]   rdata
);

  logic [sv39pm_pkg::WORD_W-1:0] mem [sv39pm_pkg::STORE_DEPTH];
  logic [sv39pm_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/sv39pm_walker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sv39pm_walker
// sequencer: clear pass, table walk, allocation, leaf write and store reads
// ----------------------------------------------------------------------------
module sv39pm_walker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              func,
  input  wire logic [sv39pm_pkg::VA_W-1:0]       virt_addr,
  input  wire logic [sv39pm_pkg::PA_W-1:0]       phys_addr,
  input  wire logic [sv39pm_pkg::SIZE_W-1:0]     size_bytes,
  input  wire logic [sv39pm_pkg::PROT_W-1:0]     prot_bits,
  input  wire logic [sv39pm_pkg::TNUM_W-1:0]     table_number,
  input  wire logic [sv39pm_pkg::ENTRY_W-1:0]    entry_number,
  input  wire logic [sv39pm_pkg::PPN_W-1:0]      base_ppn,
  input  wire logic [sv39pm_pkg::WORD_W-1:0]     rdata,
  output sv39pm_pkg::mem_req_t                   req,
  output sv39pm_pkg::result_t                    res
);

  localparam int TAB_W   = sv39pm_pkg::TAB_W;
  localparam int ADDR_W  = sv39pm_pkg::ADDR_W;
  localparam int ENTRY_W = sv39pm_pkg::ENTRY_W;
  localparam int PPN_W   = sv39pm_pkg::PPN_W;
  localparam int VPN_W   = sv39pm_pkg::VPN_W;
  localparam int CNT_W   = sv39pm_pkg::CNT_W;
  localparam int SIZE_W  = sv39pm_pkg::SIZE_W;
  localparam int PROT_W  = sv39pm_pkg::PROT_W;
  localparam int PAGE_SH = sv39pm_pkg::PAGE_SH;
  localparam int TABLES  = sv39pm_pkg::TABLES;

  sv39pm_pkg::state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [ENTRY_W-1:0] swp_cnt_r, swp_cnt_nxt;
  logic [VPN_W-1:0]   va_pg_r, va_pg_nxt;
  logic [PPN_W-1:0]   pa_pg_r, pa_pg_nxt;
  logic [PROT_W-1:0]  prot_r, prot_nxt;
  logic [CNT_W-1:0]   pages_r, pages_nxt;
  logic [CNT_W-1:0]   done_r, done_nxt;
  logic [TAB_W-1:0]   tab_r, tab_nxt;
  logic               lvl_r, lvl_nxt;      // high: level 2, low: level 1
  logic [TAB_W:0]     nf_r, nf_nxt;
  logic [TABLES-1:0]  dirty_r, dirty_nxt;  // table written since last zeroed
  logic               rd_ok_r, rd_ok_nxt;

  logic [SIZE_W-1:0]  size_cap;
  logic [SIZE_W:0]    size_round;
  logic [ENTRY_W-1:0] idx_walk;
  logic [PPN_W-1:0]   rel;
  logic               rel_ok;
  logic               nf_full;
  logic [TAB_W-1:0]   nf_tab;
  logic [PPN_W-1:0]   ptr_ppn;
  logic [63:0]        ptr_word;
  logic [63:0]        leaf_word;
  logic [CNT_W-1:0]   done_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sv39pm_pkg::ST_CLR;
      clr_cnt_r <= '0;
      nf_r      <= (TAB_W+1)'(1);
      dirty_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      nf_r      <= nf_nxt;
      dirty_r   <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    swp_cnt_r <= swp_cnt_nxt;
    va_pg_r   <= va_pg_nxt;
    pa_pg_r   <= pa_pg_nxt;
    prot_r    <= prot_nxt;
    pages_r   <= pages_nxt;
    done_r    <= done_nxt;
    tab_r     <= tab_nxt;
    lvl_r     <= lvl_nxt;
    rd_ok_r   <= rd_ok_nxt;
  end

  always_comb begin
    size_cap   = (size_bytes > sv39pm_pkg::SIZE_CAP) ? sv39pm_pkg::SIZE_CAP : size_bytes;
    size_round = {1'b0, size_cap} + (SIZE_W+1)'((1 << PAGE_SH) - 1);
    idx_walk   = lvl_r ? va_pg_r[3*ENTRY_W-1:2*ENTRY_W] : va_pg_r[2*ENTRY_W-1:ENTRY_W];
    rel        = rdata[PPN_W+9:10] - base_ppn;
    rel_ok     = (rel < PPN_W'(TABLES));
    nf_full    = (nf_r >= (TAB_W+1)'(TABLES));
    nf_tab     = nf_r[TAB_W-1:0];
    ptr_ppn    = base_ppn + PPN_W'(nf_r);
    ptr_word   = {10'b0, ptr_ppn, 9'b0, 1'b1};
    leaf_word  = {10'b0, pa_pg_r, prot_r};
    done_inc   = done_r + CNT_W'(1);
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    swp_cnt_nxt = swp_cnt_r;
    va_pg_nxt   = va_pg_r;
    pa_pg_nxt   = pa_pg_r;
    prot_nxt    = prot_r;
    pages_nxt   = pages_r;
    done_nxt    = done_r;
    tab_nxt     = tab_r;
    lvl_nxt     = lvl_r;
    nf_nxt      = nf_r;
    dirty_nxt   = dirty_r;
    rd_ok_nxt   = rd_ok_r;
    req         = '0;
    res         = '0;
    busy        = 1'b1;

    case (state_r)
      sv39pm_pkg::ST_CLR: begin
        req.we      = 1'b1;
        req.waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(sv39pm_pkg::STORE_DEPTH - 1)) begin
          state_nxt = sv39pm_pkg::ST_IDLE;
        end
      end

      sv39pm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (func == sv39pm_pkg::FUNC_READ) begin
            req.re    = 1'b1;
            req.raddr = {TAB_W'(table_number), entry_number};
            rd_ok_nxt = (32'(table_number) < 32'(TABLES));
            state_nxt = sv39pm_pkg::ST_RWAIT;
          end else begin
            va_pg_nxt = virt_addr[VPN_W+PAGE_SH-1:PAGE_SH];
            pa_pg_nxt = phys_addr[PPN_W+PAGE_SH-1:PAGE_SH];
            prot_nxt  = prot_bits;
            pages_nxt = size_round[CNT_W+PAGE_SH-1:PAGE_SH];
            done_nxt  = '0;
            tab_nxt   = '0;
            lvl_nxt   = 1'b1;
            if (size_round[CNT_W+PAGE_SH-1:PAGE_SH] == '0) begin
              res.valid  = 1'b1;
              res.status = sv39pm_pkg::STAT_OK;
            end else begin
              state_nxt = sv39pm_pkg::ST_WRD;
            end
          end
        end
      end

      sv39pm_pkg::ST_RWAIT: begin
        res.valid  = 1'b1;
        res.status = sv39pm_pkg::STAT_OK;
        res.word   = rd_ok_r ? rdata : '0;
        state_nxt  = sv39pm_pkg::ST_IDLE;
      end

      sv39pm_pkg::ST_WRD: begin
        req.re    = 1'b1;
        req.raddr = {tab_r, idx_walk};
        state_nxt = sv39pm_pkg::ST_WCHK;
      end

      sv39pm_pkg::ST_WCHK: begin
        if (rdata[0]) begin
          // valid entry: follow as a pointer into the pool
          if (!rel_ok) begin
            res.valid  = 1'b1;
            res.status = sv39pm_pkg::STAT_FOREIGN;
            res.pages  = done_r;
            state_nxt  = sv39pm_pkg::ST_IDLE;
          end else begin
            tab_nxt   = rel[TAB_W-1:0];
            lvl_nxt   = 1'b0;
            state_nxt = lvl_r ? sv39pm_pkg::ST_WRD : sv39pm_pkg::ST_LEAF;
          end
        end else if (nf_full) begin
          res.valid  = 1'b1;
          res.status = sv39pm_pkg::STAT_NO_TABLE;
          res.pages  = done_r;
          state_nxt  = sv39pm_pkg::ST_IDLE;
        end else if (dirty_r[nf_tab]) begin
          swp_cnt_nxt = '0;
          state_nxt   = sv39pm_pkg::ST_SWP;
        end else begin
          req.we                  = 1'b1;
          req.waddr               = {tab_r, idx_walk};
          req.wdata               = ptr_word;
          dirty_nxt[tab_r]        = 1'b1;
          tab_nxt                 = nf_tab;
          nf_nxt                  = nf_r + (TAB_W+1)'(1);
          lvl_nxt                 = 1'b0;
          state_nxt = lvl_r ? sv39pm_pkg::ST_WRD : sv39pm_pkg::ST_LEAF;
        end
      end

      sv39pm_pkg::ST_SWP: begin
        // zero the table before handing it out
        req.we      = 1'b1;
        req.waddr   = {nf_tab, swp_cnt_r};
        swp_cnt_nxt = swp_cnt_r + ENTRY_W'(1);
        if (swp_cnt_r == '1) begin
          dirty_nxt[nf_tab] = 1'b0;
          state_nxt         = sv39pm_pkg::ST_ALLOC;
        end
      end

      sv39pm_pkg::ST_ALLOC: begin
        req.we           = 1'b1;
        req.waddr        = {tab_r, idx_walk};
        req.wdata        = ptr_word;
        dirty_nxt[tab_r] = 1'b1;
        tab_nxt          = nf_tab;
        nf_nxt           = nf_r + (TAB_W+1)'(1);
        lvl_nxt          = 1'b0;
        state_nxt = lvl_r ? sv39pm_pkg::ST_WRD : sv39pm_pkg::ST_LEAF;
      end

      sv39pm_pkg::ST_LEAF: begin
        req.we           = 1'b1;
        req.waddr        = {tab_r, va_pg_r[ENTRY_W-1:0]};
        req.wdata        = leaf_word;
        dirty_nxt[tab_r] = 1'b1;
        done_nxt         = done_inc;
        va_pg_nxt        = va_pg_r + VPN_W'(1);
        pa_pg_nxt        = pa_pg_r + PPN_W'(1);
        tab_nxt          = '0;
        lvl_nxt          = 1'b1;
        if (done_inc == pages_r) begin
          res.valid  = 1'b1;
          res.status = sv39pm_pkg::STAT_OK;
          res.pages  = done_inc;
          state_nxt  = sv39pm_pkg::ST_IDLE;
        end else begin
          state_nxt = sv39pm_pkg::ST_WRD;
        end
      end

      default: begin
        state_nxt = sv39pm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/sv39_page_mapper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sv39_page_mapper
// installs 4 KiB sv39 leaf mappings into a local three-level table pool
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole table store to zero, one entry a
// cycle, with busy high; cfg writes are taken during the sweep. An item is
// taken when start is high and busy is low. A read item is accepted, then
// its word is returned from ST_RWAIT with busy high. A map item is accepted,
// then each page goes through read and check at level 2, read and check at
// level 1, and the leaf write; a zero-length map is finished in the cycle
// it is accepted and busy never rises. Handing out a table that is still
// clean adds no state; one that was written while still unallocated is
// first zeroed entry by entry in ST_SWP, then gets its pointer written in
// ST_ALLOC. A map that stops on an error ends at the check that found it.
// Each result word shows on the out_ ports for exactly one cycle with
// out_valid high, in the first cycle that busy is low again (for a
// zero-length map, the cycle after it was taken); the receiver cannot
// stall, so it must take the word in that cycle.
// ----------------------------------------------------------------------------
module sv39_page_mapper (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // command side
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_func,
  input  wire logic [sv39pm_pkg::VA_W-1:0]         in_virt_addr,
  input  wire logic [sv39pm_pkg::PA_W-1:0]         in_phys_addr,
  input  wire logic [sv39pm_pkg::SIZE_W-1:0]       in_size_bytes,
  input  wire logic [sv39pm_pkg::PROT_W-1:0]       in_prot_bits,
  input  wire logic [sv39pm_pkg::TNUM_W-1:0]       in_table_number,
  input  wire logic [sv39pm_pkg::ENTRY_W-1:0]      in_entry_number,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [sv39pm_pkg::PPN_W-1:0]        cfg_wdata,
  // result side
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic [sv39pm_pkg::CNT_W-1:0]             out_pages_done,
  output logic [sv39pm_pkg::WORD_W-1:0]            out_read_word
);

  // table_base_ppn register
  logic [sv39pm_pkg::PPN_W-1:0]  base_ppn_r;

  // result word register
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [sv39pm_pkg::CNT_W-1:0]  out_pages_r;
  logic [sv39pm_pkg::WORD_W-1:0] out_word_r;

  sv39pm_pkg::mem_req_t          mem_req;
  sv39pm_pkg::result_t           res;
  logic [sv39pm_pkg::WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ppn_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_ppn_r <= cfg_wdata;
      end
      out_valid_r <= res.valid;
    end
  end

  // payload only loads when a word finishes
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r <= res.status;
      out_pages_r  <= res.pages;
      out_word_r   <= res.word;
    end
  end

  // sequencer: clear pass, walk, allocate, zero tables, write leaves, store reads
  sv39pm_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (in_func),
    .virt_addr    (in_virt_addr),
    .phys_addr    (in_phys_addr),
    .size_bytes   (in_size_bytes),
    .prot_bits    (in_prot_bits),
    .table_number (in_table_number),
    .entry_number (in_entry_number),
    .base_ppn     (base_ppn_r),
    .rdata        (mem_rdata),
    .req          (mem_req),
    .res          (res)
  );

  // table store, one read and one write port
  sv39pm_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pages_done = out_pages_r;
  assign out_read_word  = out_word_r;

endmodule
`default_nettype wire
